### src/mbm_pkg.sv
// Shared constants, types and the constant-divide helper for the Mandelbrot membership block.
package mbm_pkg;

  // Field and register widths
  localparam int CoordW   = 14;
  localparam int IterW    = 10;
  localparam int LimitW   = 13;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 13;

  // Datapath widths
  localparam int ProdW  = 2 * CoordW + 1;  // room for 2*re*im
  localparam int MagW   = ProdW - 1;       // magnitude of product plus bias
  localparam int QuotW  = 19;              // signed rounded quotient
  localparam int SumW   = 21;              // signed next re / im
  localparam int AbsW   = SumW + 1;        // |re| + |im|

  // Fixed-point rounding: (p + 500) / 1000, truncating toward zero
  localparam int RoundBias = 500;
  localparam int Scale     = 1000;
  localparam int RecipSh   = 38;
  localparam int RecipW    = 29;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipSh) / Scale + 64'd1);
  localparam int FullW     = MagW + RecipW;

  // Register reset values
  localparam logic [IterW-1:0]  MaxIterReset = IterW'(255);
  localparam logic [LimitW-1:0] EscapeReset  = LimitW'(5000);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_ITER = 1'b0,
    REG_ESCAPE   = 1'b1
  } cfg_reg_t;

  // Round a scaled product back to scale 1000; the divide is a reciprocal multiply
  function automatic logic signed [QuotW-1:0] round_scale(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] biased;
    logic                    neg;
    logic [ProdW-1:0]        abs_val;
    logic [FullW-1:0]        full;
    logic [QuotW-1:0]        qmag;
    biased  = p + ProdW'(RoundBias);
    neg     = biased[ProdW-1];
    abs_val = neg ? ProdW'(-biased) : ProdW'(biased);
    full    = FullW'(abs_val[MagW-1:0]) * FullW'(Recip);
    qmag    = full[RecipSh +: QuotW];
    round_scale = neg ? QuotW'(-qmag) : QuotW'(qmag);
  endfunction

endpackage

### src/mandelbrot_pixel_membership.sv
// Escape-time Mandelbrot membership test on one multiplier and one reciprocal divider.
// Each iteration steps through the phases square re, square im, cross product, divide cross and check;
//   a max_iterations of zero gives its result without running any iteration.
// Flow: one point at a time, no new point taken until the last result is registered; each
//   iteration takes three products through the single multiplier and rounding divider.
// Reset: max_iterations returns to 255, escape_limit to 5000, no point in flight.
module mandelbrot_pixel_membership
  import mbm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [CoordW-1:0]   cx,
  input  logic signed [CoordW-1:0]   cy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       inside_res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIdxW-1:0]         cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PH_SQ_RE,
    PH_SQ_IM,
    PH_CROSS,
    PH_DIV_CROSS,
    PH_CHECK
  } phase_t;

  state_t                    state;
  phase_t                    phase;
  logic [IterW-1:0]          iter_cnt;
  logic [IterW-1:0]          max_iterations;
  logic [LimitW-1:0]         escape_limit;
  logic signed [CoordW-1:0]  c_re;
  logic signed [CoordW-1:0]  c_im;
  logic signed [CoordW-1:0]  re;
  logic signed [CoordW-1:0]  im;
  logic signed [ProdW-1:0]   prod;
  logic signed [QuotW-1:0]   sq_re;
  logic signed [QuotW-1:0]   sq_im;
  logic signed [QuotW-1:0]   cross_term;
  logic                      fin_inside;

  logic signed [CoordW-1:0]  mul_a;
  logic signed [CoordW-1:0]  mul_b;
  logic signed [ProdW-1:0]   mul_out;
  logic signed [QuotW-1:0]   div_out;
  logic signed [SumW-1:0]    re_next;
  logic signed [SumW-1:0]    im_next;
  logic [AbsW-1:0]           l1_mag;
  logic                      escaped;
  logic                      last_iter;
  logic                      out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Shared multiplier: re*re, then im*im, then re*im
  assign mul_a   = (phase == PH_SQ_IM) ? im : re;
  assign mul_b   = (phase == PH_SQ_RE) ? re : im;
  assign mul_out = ProdW'(mul_a * mul_b);

  // Shared rounding divider works on the product latched last cycle
  assign div_out = round_scale(prod);

  // Next z and L1 escape test
  assign re_next = SumW'(sq_re) - SumW'(sq_im) + SumW'(c_re);
  assign im_next = SumW'(cross_term) + SumW'(c_im);
  assign l1_mag  = AbsW'(re_next[SumW-1] ? -re_next : re_next)
                 + AbsW'(im_next[SumW-1] ? -im_next : im_next);
  assign escaped   = l1_mag > AbsW'(escape_limit);
  assign last_iter = (iter_cnt + IterW'(1)) == max_iterations;

  // Sequencer, configuration registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_SQ_RE;
      iter_cnt       <= '0;
      out_valid      <= 1'b0;
      max_iterations <= MaxIterReset;
      escape_limit   <= EscapeReset;
    end else begin
      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MAX_ITER: max_iterations <= cfg_data[IterW-1:0];
          REG_ESCAPE:   escape_limit   <= cfg_data[LimitW-1:0];
          default:      ;
        endcase
      end

      // Drop the result once taken, unless a new one replaces it this cycle
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_re     <= cx;
            c_im     <= cy;
            re       <= '0;
            im       <= '0;
            iter_cnt <= '0;
            phase    <= PH_SQ_RE;
            if (max_iterations == '0) begin
              fin_inside <= 1'b1;
              state      <= S_FINISH;
            end else begin
              state <= S_RUN;
            end
          end
        end

        S_RUN: begin
          unique case (phase)
            PH_SQ_RE: begin
              prod  <= mul_out;
              phase <= PH_SQ_IM;
            end
            PH_SQ_IM: begin
              prod  <= mul_out;
              sq_re <= div_out;
              phase <= PH_CROSS;
            end
            PH_CROSS: begin
              prod  <= ProdW'(mul_out <<< 1);
              sq_im <= div_out;
              phase <= PH_DIV_CROSS;
            end
            PH_DIV_CROSS: begin
              cross_term <= div_out;
              phase      <= PH_CHECK;
            end
            PH_CHECK: begin
              // Values that continue are bounded by escape_limit, so they fit the coordinate width
              re       <= re_next[CoordW-1:0];
              im       <= im_next[CoordW-1:0];
              iter_cnt <= iter_cnt + IterW'(1);
              phase    <= PH_SQ_RE;
              if (escaped) begin
                fin_inside <= 1'b0;
                state      <= S_FINISH;
              end else if (last_iter) begin
                fin_inside <= 1'b1;
                state      <= S_FINISH;
              end
            end
            default: phase <= PH_SQ_RE;
          endcase
        end

        S_FINISH: begin
          // Hold until the result register is free
          if (out_free) begin
            out_valid  <= 1'b1;
            inside_res <= fin_inside;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
